/* rtl/core/url_pkg.sv */
package url_pkg;

    // Input request: one edge of the echo pin.
    typedef struct packed {
        logic        echo_level;
        logic [31:0] timestamp_us;
    } t_in_item;

    // Range events reported with each result.
    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_CLOSE = 2'd1,
        EV_FAR   = 2'd2
    } t_range_event;

    // Result request: event and filtered distance.
    typedef struct packed {
        t_range_event range_event;
        logic [31:0]  distance_q16;
    } t_out_item;

    // Classified edge handed from the front end to the back end.
    typedef struct packed {
        logic        is_rise;
        logic [31:0] tof;
    } t_q_entry;

    // Configuration as the back end sees it, with the band bounds precomputed.
    typedef struct packed {
        logic [31:0] scale_q32;
        logic [23:0] bias_q16;
        logic [31:0] miss_thresh_q16;
        logic        band_lo_neg;
        logic [23:0] band_lo;
        logic [24:0] band_hi;
    } t_cfg;

    // Queue status flags.
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    // Register indexes.
    localparam logic [2:0] CFG_SCALE       = 3'd0;
    localparam logic [2:0] CFG_BIAS        = 3'd1;
    localparam logic [2:0] CFG_MISS_THRESH = 3'd2;
    localparam logic [2:0] CFG_CLOSE_THRESH = 3'd3;
    localparam logic [2:0] CFG_CLOSE_TOL   = 3'd4;

    // Register reset values.
    localparam logic [31:0] SCALE_RESET        = 32'd28927163;
    localparam logic [23:0] BIAS_RESET         = 24'd15688;
    localparam logic [31:0] MISS_THRESH_RESET  = 32'd7864320;
    localparam logic [23:0] CLOSE_THRESH_RESET = 24'd786432;
    localparam logic [23:0] CLOSE_TOL_RESET    = 24'd65536;

    // Depth of the queue between front and back end.
    localparam int Q_DEPTH = 2;

endpackage

/* rtl/core/url_front.sv */
module url_front
    import url_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_in_item  i_in_item,
    output logic      o_stall,
    input  t_q_status i_q_status,
    output logic      o_push,
    output t_q_entry  o_entry
);

    logic [31:0] r_rise_time;
    logic [31:0] n_rise_time;

    // Accept whenever the queue has room.
    assign o_stall = i_q_status.full;
    assign o_push  = i_valid && !i_q_status.full;

    // Classify the edge and work out the time of flight modulo 2^32.
    always_comb begin
        n_rise_time = r_rise_time;
        if (o_push && i_in_item.echo_level) begin
            n_rise_time = i_in_item.timestamp_us;
        end
        o_entry.is_rise = i_in_item.echo_level;
        o_entry.tof     = i_in_item.timestamp_us - r_rise_time;
    end

    // Timestamp of the latest rising edge.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rise_time <= '0;
        end else begin
            r_rise_time <= n_rise_time;
        end
    end

endmodule

/* rtl/core/url_queue.sv */
module url_queue
    import url_pkg::*;
#(
    parameter int DEPTH = Q_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_q_entry  i_entry,
    input  logic      i_pop,
    output t_q_entry  o_entry,
    output t_q_status o_status
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_q_entry      r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic [PW-1:0] n_wr_ptr;
    logic [PW-1:0] n_rd_ptr;
    logic [CW-1:0] n_count;

    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == FULL_CNT);
    assign o_entry        = r_mem[r_rd_ptr];

    // Pointer and fill count update.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

/* rtl/core/url_back.sv */
module url_back
    import url_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_q_valid,
    input  t_q_entry  i_q_entry,
    output logic      o_q_pop,
    output logic      o_valid,
    output t_out_item o_out_item,
    input  logic      i_stall
);

    logic         w_en;

    // Stage 1: product of scale and time of flight.
    logic         r_s1_valid;
    logic         r_s1_rise;
    logic [63:0]  r_s1_prod;

    // Stage 2: converted sample and miss check.
    logic         r_s2_valid;
    logic         r_s2_fall;
    logic         r_s2_keep;
    logic [31:0]  r_s2_sample;
    logic [48:0]  w_sample;

    // Stage 3: filter, hysteresis and result register.
    logic         r_s3_valid;
    t_out_item    r_out;
    logic [31:0]  r_filt;
    logic         r_near;
    logic [31:0]  n_filt;
    logic         n_near;
    t_range_event n_event;
    logic [32:0]  w_sum;

    // The whole pipeline advances unless a finished result is held off.
    assign w_en    = !r_s3_valid || !i_stall;
    assign o_q_pop = w_en && i_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else if (w_en) begin
            r_s1_valid <= i_q_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    // Multiply stage.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_rise <= i_q_entry.is_rise;
            r_s1_prod <= 64'(i_q_entry.tof) * 64'(i_cfg.scale_q32);
        end
    end

    // Truncate to Q16, add the offset and compare against the miss threshold.
    assign w_sample = {1'b0, r_s1_prod[63:16]} + {25'd0, i_cfg.bias_q16};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_fall   <= !r_s1_rise;
            r_s2_keep   <= !r_s1_rise && (w_sample <= {17'd0, i_cfg.miss_thresh_q16});
            r_s2_sample <= w_sample[31:0];
        end
    end

    // Mean filter and hysteresis on the resulting distance.
    assign w_sum = {1'b0, r_filt} + {1'b0, r_s2_sample};

    always_comb begin
        n_filt  = r_s2_keep ? w_sum[32:1] : r_filt;
        n_near  = r_near;
        n_event = EV_NONE;
        if (r_s2_fall) begin
            if (!i_cfg.band_lo_neg && (n_filt < {8'd0, i_cfg.band_lo}) && !r_near) begin
                n_near  = 1'b1;
                n_event = EV_CLOSE;
            end else if ((n_filt > {7'd0, i_cfg.band_hi}) && r_near) begin
                n_near  = 1'b0;
                n_event = EV_FAR;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filt <= '0;
            r_near <= 1'b0;
        end else if (w_en && r_s2_valid) begin
            r_filt <= n_filt;
            r_near <= n_near;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out.range_event  <= n_event;
            r_out.distance_q16 <= n_filt;
        end
    end

    assign o_valid    = r_s3_valid;
    assign o_out_item = r_out;

endmodule

/* rtl/core/ultrasonic_range_filter.sv */
// Ultrasonic echo ranging with a mean filter and close/far hysteresis.
// Each result passes through the queue and then the three back-end stages.
// Throughput: one edge per cycle unless the output is stalled, set by the three-stage back-end pipeline.
// An output stall freezes the back end; the two-entry queue keeps accepting until full.
// Reset (synchronous, active low) clears rise time, queue, pipeline valid flags,
// filter and near flag and loads the register defaults.
module ultrasonic_range_filter
    import url_pkg::*;
#(
    parameter int QUEUE_DEPTH = Q_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_in_item  i_in_item,
    output logic      o_stall,
    output logic      o_valid,
    output t_out_item o_out_item,
    input  logic      i_stall,
    input  logic      i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    logic [31:0] r_scale;
    logic [23:0] r_bias;
    logic [31:0] r_miss;
    logic [23:0] r_close_thresh;
    logic [23:0] r_close_tol;

    t_cfg        w_cfg;
    logic [24:0] w_lo;
    t_q_status   w_q_status;
    t_q_entry    w_push_entry;
    t_q_entry    w_pop_entry;
    logic        w_push;
    logic        w_pop;

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale        <= SCALE_RESET;
            r_bias         <= BIAS_RESET;
            r_miss         <= MISS_THRESH_RESET;
            r_close_thresh <= CLOSE_THRESH_RESET;
            r_close_tol    <= CLOSE_TOL_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SCALE:        r_scale        <= i_cfg_data;
                CFG_BIAS:         r_bias         <= i_cfg_data[23:0];
                CFG_MISS_THRESH:  r_miss         <= i_cfg_data;
                CFG_CLOSE_THRESH: r_close_thresh <= i_cfg_data[23:0];
                CFG_CLOSE_TOL:    r_close_tol    <= i_cfg_data[23:0];
                default: begin
                end
            endcase
        end
    end

    // Hysteresis band bounds; the lower one may fall below zero.
    assign w_lo                  = {1'b0, r_close_thresh} - {1'b0, r_close_tol};
    assign w_cfg.scale_q32       = r_scale;
    assign w_cfg.bias_q16        = r_bias;
    assign w_cfg.miss_thresh_q16 = r_miss;
    assign w_cfg.band_lo_neg     = (r_close_tol > r_close_thresh);
    assign w_cfg.band_lo         = w_lo[23:0];
    assign w_cfg.band_hi         = {1'b0, r_close_thresh} + {1'b0, r_close_tol};

    url_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_in_item  (i_in_item),
        .o_stall    (o_stall),
        .i_q_status (w_q_status),
        .o_push     (w_push),
        .o_entry    (w_push_entry)
    );

    url_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_entry  (w_push_entry),
        .i_pop    (w_pop),
        .o_entry  (w_pop_entry),
        .o_status (w_q_status)
    );

    url_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_q_valid  (!w_q_status.empty),
        .i_q_entry  (w_pop_entry),
        .o_q_pop    (w_pop),
        .o_valid    (o_valid),
        .o_out_item (o_out_item),
        .i_stall    (i_stall)
    );

    // A close event always reports a distance below the band center.
    a_close_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out_item.range_event == EV_CLOSE)
            |-> (o_out_item.distance_q16 < {8'd0, r_close_thresh}))
        else $error("close event above band center");

    // A far event always reports a distance above the band center.
    a_far_above: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out_item.range_event == EV_FAR)
            |-> (o_out_item.distance_q16 > {8'd0, r_close_thresh}))
        else $error("far event below band center");

    // The queue can only become full after a request was accepted.
    a_full_after_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(i_valid))
        else $error("queue filled without a request");

    // The queue never pops while empty.
    a_no_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_status.empty)
        else $error("pop from empty queue");

endmodule
